// ----- sv/pbrd_pkg.sv -----
// pbrd_pkg: shared types and constants of the pulse beat rate detector
// no dependencies; used by pbrd_regs, pbrd_datapath, pbrd_ctrl and the top

package pbrd_pkg;

    localparam logic [15:0] MINUTE_MS = 16'd60000;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 4;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE  = 2'd1;
    localparam logic [1:0] REG_MAX_RATE  = 2'd2;

    localparam logic signed [13:0] THRESHOLD_RST = 14'sd2;
    localparam logic [15:0] DEBOUNCE_RST = 16'd150;
    localparam logic [15:0] MAX_RATE_RST = 16'd200;

    typedef struct packed {
        logic signed [13:0] beat_threshold;
        logic [15:0]        debounce_ms;
        logic [15:0]        max_report_rate;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic sum;
        logic check;
        logic div_start;
        logic ring;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic beat;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ----- sv/pbrd_regs.sv -----
// pbrd_regs: apb-style configuration registers of the detector
// depends on pbrd_pkg

module pbrd_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pbrd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pbrd_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pbrd_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output pbrd_pkg::t_cfg                      o_cfg
);

    pbrd_pkg::t_cfg r_cfg;
    logic [1:0]     w_index;
    logic           w_write;

    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beat_threshold  <= pbrd_pkg::THRESHOLD_RST;
            r_cfg.debounce_ms     <= pbrd_pkg::DEBOUNCE_RST;
            r_cfg.max_report_rate <= pbrd_pkg::MAX_RATE_RST;
        end else if (w_write) begin
            case (w_index)
                pbrd_pkg::REG_THRESHOLD: r_cfg.beat_threshold <= $signed(pwdata[13:0]);
                pbrd_pkg::REG_DEBOUNCE:  r_cfg.debounce_ms     <= pwdata[15:0];
                pbrd_pkg::REG_MAX_RATE:  r_cfg.max_report_rate <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            pbrd_pkg::REG_THRESHOLD: prdata = 32'(r_cfg.beat_threshold);
            pbrd_pkg::REG_DEBOUNCE:  prdata = {16'd0, r_cfg.debounce_ms};
            pbrd_pkg::REG_MAX_RATE:  prdata = {16'd0, r_cfg.max_report_rate};
            default:                 prdata = '0;
        endcase
    end

endmodule

// ----- sv/pbrd_div.sv -----
// pbrd_div: radix-2 restoring divider, one quotient bit per cycle
// depends on pbrd_pkg for nothing; used by pbrd_datapath

module pbrd_div #(
    parameter int unsigned NW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [31:0]   i_divisor,
    output logic [NW-1:0] o_quotient,
    output logic          o_done
);

    localparam int unsigned CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_q;
    logic [31:0]      r_rem;
    logic [31:0]      r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [32:0]      w_shift;
    logic             w_ge;

    assign w_shift    = {r_rem, r_q[NW-1]};
    assign w_ge       = w_shift >= {1'b0, r_dvs};
    assign o_quotient = r_q;
    assign o_done     = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_shift - {1'b0, r_dvs}) : w_shift[31:0];
            r_q   <= {r_q[NW-2:0], w_ge};
        end
    end

endmodule

// ----- sv/pbrd_datapath.sv -----
// pbrd_datapath: difference window, rate ring, divider and result register
// depends on pbrd_pkg and pbrd_div

module pbrd_datapath #(
    parameter int unsigned HISTORY_DEPTH = 8,
    parameter int unsigned RATE_DEPTH    = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pbrd_pkg::t_cmd  i_cmd,
    output pbrd_pkg::t_stat o_stat,
    input  pbrd_pkg::t_cfg  i_cfg,
    input  logic [9:0]      i_sample,
    input  logic [31:0]     i_time_ms,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_beat,
    output logic [15:0]     o_rate_bpm,
    output logic [15:0]     o_average_bpm,
    output logic            o_report
);

    localparam int unsigned HI_W  = $clog2(HISTORY_DEPTH);
    localparam int unsigned RI_W  = $clog2(RATE_DEPTH);
    localparam int unsigned WS_W  = HI_W + 11;
    localparam int unsigned CMP_W = (WS_W > 14) ? WS_W : 14;
    localparam int unsigned TOT_W = RI_W + 16;

    // ring mean as a reciprocal multiply, exact for every total below 2^TOT_W
    localparam int unsigned       AVG_SH    = TOT_W + RI_W;
    localparam int unsigned       AVG_M_W   = TOT_W + 1;
    localparam longint unsigned   AVG_MUL_L = ((64'd1 << AVG_SH) + RATE_DEPTH - 1) / RATE_DEPTH;
    localparam logic [AVG_M_W-1:0] AVG_MUL  = AVG_M_W'(AVG_MUL_L);

    logic [9:0]               r_prev;
    logic [31:0]              r_time;
    logic signed [10:0]       r_diff;
    logic signed [10:0]       r_dmem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_dvalid;
    logic signed [10:0]       r_dq;
    logic                     r_dq_valid;
    logic [HI_W-1:0]          r_didx;
    logic signed [WS_W-1:0]   r_wsum;
    logic [31:0]              r_last;
    logic [15:0]              r_rmem [RATE_DEPTH];
    logic [RATE_DEPTH-1:0]    r_rvalid;
    logic [15:0]              r_rq;
    logic                     r_rq_valid;
    logic [RI_W-1:0]          r_ridx;
    logic [TOT_W-1:0]         r_total;
    logic [15:0]              r_rate;
    logic [15:0]              r_avg;
    logic                     r_beat;
    logic                     r_out_valid;
    logic                     r_out_beat;
    logic [15:0]              r_out_rate;
    logic                     r_out_report;

    logic signed [10:0]           w_dold;
    logic [15:0]                  w_rold;
    logic [31:0]                  w_elapsed;
    logic signed [CMP_W-1:0]      w_ws_ext;
    logic signed [CMP_W-1:0]      w_thr_ext;
    logic                         w_beat;
    logic [31:0]                  w_divisor;
    logic [15:0]                  w_quot;
    logic                         w_div_done;
    logic [TOT_W+AVG_M_W-1:0]     w_avg_prod;
    logic [15:0]                  w_new_avg;

    assign w_dold    = r_dq_valid ? r_dq : 11'sd0;
    assign w_rold    = r_rq_valid ? r_rq : 16'd0;
    assign w_elapsed = r_time - r_last;
    assign w_ws_ext  = CMP_W'(r_wsum);
    assign w_thr_ext = CMP_W'(i_cfg.beat_threshold);
    assign w_beat    = (w_ws_ext >= w_thr_ext) && (w_elapsed >= {16'd0, i_cfg.debounce_ms});

    assign w_divisor  = (w_elapsed == 32'd0) ? 32'd1 : w_elapsed;
    assign w_avg_prod = r_total * AVG_MUL;
    assign w_new_avg  = w_avg_prod[AVG_SH +: 16];

    pbrd_div #(
        .NW (16)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (pbrd_pkg::MINUTE_MS),
        .i_divisor  (w_divisor),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    assign o_stat.beat     = w_beat;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_beat        = r_out_beat;
    assign o_rate_bpm    = r_out_rate;
    assign o_average_bpm = r_avg;
    assign o_report      = r_out_report;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_didx      <= '0;
            r_wsum      <= '0;
            r_dvalid    <= '0;
            r_last      <= '0;
            r_ridx      <= '0;
            r_total     <= '0;
            r_rvalid    <= '0;
            r_avg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_prev <= i_sample;
            end
            if (i_cmd.sum) begin
                r_wsum           <= r_wsum - WS_W'(w_dold) + WS_W'(r_diff);
                r_dvalid[r_didx] <= 1'b1;
                r_didx <= (r_didx == HI_W'(HISTORY_DEPTH - 1)) ? '0 : r_didx + HI_W'(1);
            end
            if (i_cmd.ring) begin
                r_total          <= r_total - TOT_W'(w_rold) + TOT_W'(w_quot);
                r_rvalid[r_ridx] <= 1'b1;
                r_ridx <= (r_ridx == RI_W'(RATE_DEPTH - 1)) ? '0 : r_ridx + RI_W'(1);
                r_last <= r_time;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_avg       <= w_new_avg;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and ring memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_time     <= i_time_ms;
            r_diff     <= $signed({1'b0, i_sample}) - $signed({1'b0, r_prev});
            r_dq       <= r_dmem[r_didx];
            r_dq_valid <= r_dvalid[r_didx];
            r_rq       <= r_rmem[r_ridx];
            r_rq_valid <= r_rvalid[r_ridx];
        end
        if (i_cmd.sum) begin
            r_dmem[r_didx] <= r_diff;
        end
        if (i_cmd.check) begin
            r_beat <= w_beat;
        end
        if (i_cmd.ring) begin
            r_rate         <= w_quot;
            r_rmem[r_ridx] <= w_quot;
        end
        if (i_cmd.out_load) begin
            r_out_beat   <= r_beat;
            r_out_rate   <= r_beat ? r_rate : 16'd0;
            r_out_report <= r_beat && (r_rate <= w_new_avg)
                         && (r_rate <= i_cfg.max_report_rate);
        end
    end

`ifndef ASSERT_OFF
    a_report_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_report || r_out_beat))
        else $error("report without beat");

    a_rate_zero_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_beat) |-> (r_out_rate == 16'd0))
        else $error("rate set without beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("pending word overwritten");

    a_avg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_avg <= pbrd_pkg::MINUTE_MS))
        else $error("average out of range");
`endif

endmodule

// ----- sv/pbrd_ctrl.sv -----
// pbrd_ctrl: sequencer for one sample word through the datapath
// depends on pbrd_pkg

module pbrd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pbrd_pkg::t_stat i_stat,
    output pbrd_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_RDIV,
        ST_RING,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.beat) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_RDIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RDIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_RING;
                end
            end
            ST_RING: begin
                o_cmd.ring = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/pulse_beat_rate_detector.sv -----
// channel  direction  handshake                   word
// in       input      i_in_valid / o_in_ready     i_sample, i_time_ms
// out      output     o_out_valid / i_out_ready   o_beat, o_rate_bpm, o_average_bpm, o_report
// cfg      input      psel, penable, pwrite       paddr, pwdata, prdata, pready
// a word without a beat goes through the load, sum, check and done states to the result register
// a beat word also goes through the divide and ring states, the divide state waiting on the
// 16-step radix-2 divider for 60000 / elapsed; the ring mean is a constant reciprocal multiply
// one word at a time; the next word is accepted while a result waits in the output register
// synchronous active-low reset clears window and ring sums and valid bits, config, state, out valid
// depends on pbrd_pkg, pbrd_regs, pbrd_ctrl, pbrd_datapath

module pulse_beat_rate_detector #(
    parameter int unsigned HISTORY_DEPTH = 8,
    parameter int unsigned RATE_DEPTH    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [9:0]                      i_sample,
    input  logic [31:0]                     i_time_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_beat,
    output logic [15:0]                     o_rate_bpm,
    output logic [15:0]                     o_average_bpm,
    output logic                            o_report,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pbrd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pbrd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pbrd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    pbrd_pkg::t_cfg  w_cfg;
    pbrd_pkg::t_cmd  w_cmd;
    pbrd_pkg::t_stat w_stat;

    pbrd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pbrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pbrd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .RATE_DEPTH    (RATE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg         (w_cfg),
        .i_sample      (i_sample),
        .i_time_ms     (i_time_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_beat        (o_beat),
        .o_rate_bpm    (o_rate_bpm),
        .o_average_bpm (o_average_bpm),
        .o_report      (o_report)
    );

endmodule
